// ===== hdl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console character writer package
// Shared constants for the command codes, control characters and registers.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_TEXT_COLOR = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROWS       = 2'd2;

    localparam logic [7:0] TEXT_COLOR_RESET = 8'd15;
    localparam logic [7:0] COLUMNS_RESET    = 8'd80;
    localparam logic [6:0] ROWS_RESET       = 7'd25;

    localparam logic FUNC_PUT  = 1'b0;
    localparam logic FUNC_MOVE = 1'b1;

    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;

endpackage

// ===== hdl/tcw_cursor.sv =====
// ----------------------------------------------------------------------------
// Text console cursor tracker
// Holds the cursor column and row and works out the cell written by a
// command and the cursor that follows it, all combinationally.
// ----------------------------------------------------------------------------
module tcw_cursor #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 64,
    parameter int TAB_STOP    = 4,
    localparam int CW   = $clog2(MAX_COLUMNS),
    localparam int RW   = $clog2(MAX_ROWS),
    localparam int NC_W = $clog2(MAX_COLUMNS + 1),
    localparam int NR_W = $clog2(MAX_ROWS + 1)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic            func,
    input  logic [7:0]      char_code,
    input  logic [6:0]      new_column,
    input  logic [5:0]      new_row,
    input  logic [NC_W-1:0] ncols,
    input  logic [NR_W-1:0] nrows,
    output logic            cell_write,
    output logic [CW-1:0]   cell_column,
    output logic [RW-1:0]   cell_row,
    output logic [CW-1:0]   column,
    output logic [RW-1:0]   row
);

    localparam int SH    = CW + 4;
    localparam int PW    = CW + SH;
    localparam int TW    = CW + 5;
    localparam int RECIP = ((2 ** SH) + TAB_STOP - 1) / TAB_STOP;

    logic [CW-1:0] column_reg;
    logic [CW-1:0] column_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;

    logic [CW-1:0] col_eff;
    logic [RW-1:0] row_eff;
    logic [CW-1:0] col_last;
    logic [RW-1:0] row_last;
    logic [RW-1:0] row_down;
    logic [PW-1:0] recip_prod;
    logic [CW-1:0] tab_quot;
    logic [TW-1:0] tab_next;
    logic [CW:0]   col_inc;
    logic          write_next;

    always_comb
    begin
        col_last = CW'(32'(ncols) - 32'd1);
        row_last = RW'(32'(nrows) - 32'd1);
        col_eff  = (32'(column_reg) >= 32'(ncols)) ? col_last : column_reg;
        row_eff  = (32'(row_reg) >= 32'(nrows)) ? row_last : row_reg;
        row_down = (32'(row_eff) + 32'd1 >= 32'(nrows)) ? '0 : RW'(32'(row_eff) + 32'd1);

        recip_prod = PW'(col_eff) * PW'(RECIP);
        tab_quot   = CW'(recip_prod >> SH);
        tab_next   = (TW'(tab_quot) + TW'(1)) * TW'(TAB_STOP);
        col_inc    = (CW + 1)'(col_eff) + (CW + 1)'(1);
    end

    always_comb
    begin
        column_next = col_eff;
        row_next    = row_eff;
        write_next  = 1'b0;
        priority if (func == tcw_pkg::FUNC_MOVE)
        begin
            column_next = (32'(new_column) >= 32'(ncols)) ? col_last : CW'(new_column);
            row_next    = (32'(new_row) >= 32'(nrows)) ? row_last : RW'(new_row);
        end
        else if (char_code == tcw_pkg::CH_NEWLINE)
        begin
            column_next = '0;
            row_next    = row_down;
        end
        else if (char_code == tcw_pkg::CH_RETURN)
        begin
            column_next = '0;
        end
        else if (char_code == tcw_pkg::CH_TAB)
        begin
            if (tab_next >= TW'(ncols))
            begin
                column_next = '0;
                row_next    = row_down;
            end
            else
            begin
                column_next = CW'(tab_next);
            end
        end
        else
        begin
            write_next = 1'b1;
            if (col_inc >= (CW + 1)'(ncols))
            begin
                column_next = '0;
                row_next    = row_down;
            end
            else
            begin
                column_next = CW'(col_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
        end
        else if (step)
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
        end
    end

    assign cell_write  = write_next;
    assign cell_column = col_eff;
    assign cell_row    = row_eff;
    assign column      = column_next;
    assign row         = row_next;

    a_hold_without_step: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> ($stable(column_reg) && $stable(row_reg)))
        else $error("cursor changed without a command");

    a_move_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (func == tcw_pkg::FUNC_MOVE) |-> !cell_write)
        else $error("cursor move wrote a cell");

endmodule

// ===== hdl/text_console_char_writer.sv =====
// ----------------------------------------------------------------------------
// Text console character writer
// Turns a stream of put-character and move-cursor commands into screen cell
// writes and cursor updates for a text-mode display.
// ----------------------------------------------------------------------------
// The block accepts one command item in every clock cycle while the output
// side is not stalled, and returns exactly one result item for each, through
// the s1 and output registers. The rate is set by the cursor update, which
// finishes within the cycle in which an item is accepted; the linear address
// multiplications run in the following stage. Configuration may be written
// only while no item is in flight.
module text_console_char_writer #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 64,
    parameter int TAB_STOP    = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,  // char_code, new_column, new_row, pad
    input  logic                           s_tuser,  // func
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [55:0]                    m_tdata,  // cell_address, cell_value,
                                                     // cursor_position, cursor_column,
                                                     // cursor_row, pad
    output logic                           m_tuser   // cell_write
);

    localparam int CW   = $clog2(MAX_COLUMNS);
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int NC_W = $clog2(MAX_COLUMNS + 1);
    localparam int NR_W = $clog2(MAX_ROWS + 1);
    localparam int AW   = RW + NC_W + 1;

    logic [7:0]      color_reg;
    logic [7:0]      columns_reg;
    logic [6:0]      rows_reg;
    logic [NC_W-1:0] ncols;
    logic [NR_W-1:0] nrows;

    logic            step;
    logic            out_load;
    logic            s1_valid_reg;
    logic            s1_valid_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    logic            cur_write;
    logic [CW-1:0]   cur_cell_col;
    logic [RW-1:0]   cur_cell_row;
    logic [CW-1:0]   cur_col;
    logic [RW-1:0]   cur_row;

    logic            s1_wr_reg;
    logic [CW-1:0]   s1_ccol_reg;
    logic [RW-1:0]   s1_crow_reg;
    logic [CW-1:0]   s1_col_reg;
    logic [RW-1:0]   s1_row_reg;
    logic [7:0]      s1_char_reg;

    logic [AW-1:0]   cell_sum;
    logic [AW-1:0]   pos_sum;

    logic            out_wr_reg;
    logic [12:0]     out_addr_reg;
    logic [15:0]     out_value_reg;
    logic [12:0]     out_pos_reg;
    logic [6:0]      out_col_reg;
    logic [5:0]      out_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg   <= tcw_pkg::TEXT_COLOR_RESET;
            columns_reg <= tcw_pkg::COLUMNS_RESET;
            rows_reg    <= tcw_pkg::ROWS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tcw_pkg::REG_TEXT_COLOR: color_reg   <= cfg_data;
                tcw_pkg::REG_COLUMNS:    columns_reg <= cfg_data;
                tcw_pkg::REG_ROWS:       rows_reg    <= cfg_data[6:0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        if (columns_reg == 8'd0)
            ncols = NC_W'(1);
        else if (32'(columns_reg) > 32'(MAX_COLUMNS))
            ncols = NC_W'(MAX_COLUMNS);
        else
            ncols = NC_W'(columns_reg);

        if (rows_reg == 7'd0)
            nrows = NR_W'(1);
        else if (32'(rows_reg) > 32'(MAX_ROWS))
            nrows = NR_W'(MAX_ROWS);
        else
            nrows = NR_W'(rows_reg);
    end

    assign out_load = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || out_load;
    assign step     = s_tvalid && s_tready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (step)
            s1_valid_next = 1'b1;
        else if (out_load)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    tcw_cursor #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .TAB_STOP    (TAB_STOP)
    ) u_cursor (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .func        (s_tuser),
        .char_code   (s_tdata[7:0]),
        .new_column  (s_tdata[14:8]),
        .new_row     (s_tdata[20:15]),
        .ncols       (ncols),
        .nrows       (nrows),
        .cell_write  (cur_write),
        .cell_column (cur_cell_col),
        .cell_row    (cur_cell_row),
        .column      (cur_col),
        .row         (cur_row)
    );

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            s1_wr_reg   <= cur_write;
            s1_ccol_reg <= cur_cell_col;
            s1_crow_reg <= cur_cell_row;
            s1_col_reg  <= cur_col;
            s1_row_reg  <= cur_row;
            s1_char_reg <= s_tdata[7:0];
        end
    end

    assign cell_sum = AW'(s1_crow_reg) * AW'(ncols) + AW'(s1_ccol_reg);
    assign pos_sum  = AW'(s1_row_reg) * AW'(ncols) + AW'(s1_col_reg);

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_wr_reg    <= s1_wr_reg;
            out_addr_reg  <= s1_wr_reg ? 13'(cell_sum) : 13'd0;
            out_value_reg <= s1_wr_reg ? {color_reg, s1_char_reg} : 16'd0;
            out_pos_reg   <= 13'(pos_sum);
            out_col_reg   <= 7'(s1_col_reg);
            out_row_reg   <= 6'(s1_row_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_wr_reg;
    assign m_tdata  = {1'b0, out_row_reg, out_col_reg, out_pos_reg, out_value_reg,
                       out_addr_reg};

    a_col_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (32'(out_col_reg) < 32'(ncols)))
        else $error("reported column lies beyond the screen width");

    a_row_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (32'(out_row_reg) < 32'(nrows)))
        else $error("reported row lies beyond the screen height");

    a_idle_cell_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_wr_reg) |-> (out_addr_reg == 13'd0 && out_value_reg == 16'd0))
        else $error("cell fields not cleared on an item without a cell write");

    a_stage_order: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !m_tready) |=> s1_valid_reg)
        else $error("pending item dropped while the output stalled");

endmodule
